/* hdl/tok_pkg.sv */
// ---------------------------------------------------------------------------
// tok_pkg
// Shared types, constants and helper functions of the source byte tokenizer.
// ---------------------------------------------------------------------------
package tok_pkg;

   localparam int MAX_TOKENS  = 4096;
   localparam int COUNT_BITS  = 16;
   localparam int TCOUNT_BITS = $clog2(MAX_TOKENS + 1);
   localparam int FIELD_BITS  = 16;

   // classified byte queue and token queue depths, powers of two
   localparam int FRONT_DEPTH = 4;
   localparam int FRONT_PTR   = $clog2(FRONT_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR     = $clog2(OUT_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [4:0] KIND_NUM       = 5'd0;
   localparam logic [4:0] KIND_IDENT     = 5'd1;
   localparam logic [4:0] KIND_IF        = 5'd2;
   localparam logic [4:0] KIND_ELSE      = 5'd3;
   localparam logic [4:0] KIND_PRINT     = 5'd4;
   localparam logic [4:0] KIND_INPUT     = 5'd5;
   localparam logic [4:0] KIND_WHILE     = 5'd6;
   localparam logic [4:0] KIND_EXIT      = 5'd7;
   localparam logic [4:0] KIND_VAR       = 5'd8;
   localparam logic [4:0] KIND_STRING    = 5'd9;
   localparam logic [4:0] KIND_COMMENT   = 5'd10;
   localparam logic [4:0] KIND_OPERATOR  = 5'd11;
   localparam logic [4:0] KIND_EQUALS    = 5'd12;
   localparam logic [4:0] KIND_SEMICOLON = 5'd13;
   localparam logic [4:0] KIND_LPAREN    = 5'd14;
   localparam logic [4:0] KIND_RPAREN    = 5'd15;
   localparam logic [4:0] KIND_LBRACE    = 5'd16;
   localparam logic [4:0] KIND_RBRACE    = 5'd17;
   localparam logic [4:0] KIND_UNKNOWN   = 5'd18;
   localparam logic [4:0] KIND_END       = 5'd19;

   // keywords packed big-endian, as the identifier prefix register holds them
   localparam logic [39:0] WORD_IF    = 40'h0000006966;
   localparam logic [39:0] WORD_ELSE  = 40'h00656C7365;
   localparam logic [39:0] WORD_PRINT = 40'h7072696E74;
   localparam logic [39:0] WORD_INPUT = 40'h696E707574;
   localparam logic [39:0] WORD_WHILE = 40'h7768696C65;
   localparam logic [39:0] WORD_EXIT  = 40'h0065786974;
   localparam logic [39:0] WORD_VAR   = 40'h0000766172;

   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_QUOTE,
      CLS_EQUALS,
      CLS_SLASH,
      CLS_SINGLE,
      CLS_END
   } class_type;

   typedef struct packed {
      logic [7:0] data;
      class_type  cls;
      logic [4:0] single_kind;
   } item_type;

   typedef struct packed {
      logic [4:0]            kind;
      logic [7:0]            first;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] line;
      logic [FIELD_BITS-1:0] length;
      logic                  overflow;
      logic                  last;
   } token_type;

   typedef struct packed {
      logic      wr0;
      logic      wr1;
      token_type tok0;
      token_type tok1;
   } push_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
      if (32'(v) > 32'h0000FFFF) clamp_field = '1;
      else                       clamp_field = FIELD_BITS'(v);
   endfunction

   function automatic logic [4:0] keyword_kind(input logic [39:0] prefix,
                                               input logic [COUNT_BITS-1:0] len);
      keyword_kind = KIND_IDENT;
      if      (len == COUNT_BITS'(2) && prefix == WORD_IF)    keyword_kind = KIND_IF;
      else if (len == COUNT_BITS'(4) && prefix == WORD_ELSE)  keyword_kind = KIND_ELSE;
      else if (len == COUNT_BITS'(5) && prefix == WORD_PRINT) keyword_kind = KIND_PRINT;
      else if (len == COUNT_BITS'(5) && prefix == WORD_INPUT) keyword_kind = KIND_INPUT;
      else if (len == COUNT_BITS'(5) && prefix == WORD_WHILE) keyword_kind = KIND_WHILE;
      else if (len == COUNT_BITS'(4) && prefix == WORD_EXIT)  keyword_kind = KIND_EXIT;
      else if (len == COUNT_BITS'(3) && prefix == WORD_VAR)   keyword_kind = KIND_VAR;
   endfunction

   function automatic item_type classify(input logic [7:0] b, input logic end_in);
      item_type r;
      r.data        = b;
      r.single_kind = KIND_UNKNOWN;
      if (end_in || b == 8'h00)                            r.cls = CLS_END;
      else if (b == 8'h20 || b == 8'h09)                    r.cls = CLS_SPACE;
      else if (b == 8'h0D || b == 8'h0A)                    r.cls = CLS_NEWLINE;
      else if (b >= 8'h30 && b <= 8'h39)                    r.cls = CLS_DIGIT;
      else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F)
                                                            r.cls = CLS_ALPHA;
      else if (b == 8'h22)                                  r.cls = CLS_QUOTE;
      else if (b == 8'h3D)                                  r.cls = CLS_EQUALS;
      else if (b == 8'h2F)                                  r.cls = CLS_SLASH;
      else                                                  r.cls = CLS_SINGLE;
      case (b)
         8'h2B, 8'h2D, 8'h2A, 8'h3E, 8'h3C, 8'h2C: r.single_kind = KIND_OPERATOR;
         8'h3B:   r.single_kind = KIND_SEMICOLON;
         8'h28:   r.single_kind = KIND_LPAREN;
         8'h29:   r.single_kind = KIND_RPAREN;
         8'h7B:   r.single_kind = KIND_LBRACE;
         8'h7D:   r.single_kind = KIND_RBRACE;
         default: r.single_kind = KIND_UNKNOWN;
      endcase
      classify = r;
   endfunction

endpackage

/* hdl/tok_front.sv */
// ---------------------------------------------------------------------------
// tok_front
// Accepts source bytes, classifies them and queues them for the scanner.
// ---------------------------------------------------------------------------
module tok_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_source_byte,
   input  logic              req_end_marker,
   output logic              item_valid,
   input  logic              item_ready,
   output tok_pkg::item_type item
);

   tok_pkg::item_type                q_ff [tok_pkg::FRONT_DEPTH];
   tok_pkg::item_type                q_in [tok_pkg::FRONT_DEPTH];
   logic [tok_pkg::FRONT_PTR-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tok_pkg::FRONT_PTR-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tok_pkg::FRONT_PTR:0]      count_ff, count_in;
   logic                             push, pop;

   assign req_ready  = (count_ff != (tok_pkg::FRONT_PTR + 1)'(tok_pkg::FRONT_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      q_in = q_ff;
      if (push) begin
         q_in[wr_ptr_ff] = tok_pkg::classify(req_source_byte, req_end_marker);
      end
      wr_ptr_in = wr_ptr_ff + tok_pkg::FRONT_PTR'(push);
      rd_ptr_in = rd_ptr_ff + tok_pkg::FRONT_PTR'(pop);
      count_in  = count_ff + (tok_pkg::FRONT_PTR + 1)'(push)
                           - (tok_pkg::FRONT_PTR + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/tok_scan.sv */
// ---------------------------------------------------------------------------
// tok_scan
// Scanner state machine: consumes one classified byte a cycle while the token
// queue has room, and produces up to two token records, applying the token limit.
// ---------------------------------------------------------------------------
module tok_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  tok_pkg::item_type item,
   input  logic              space_ok,
   output tok_pkg::push_type push
);

   typedef enum logic [2:0] {
      M_IDLE, M_NUM, M_IDENT, M_STRING, M_COMMENT, M_EQ, M_SLASH, M_DONE
   } mode_type;

   mode_type                         mode_ff, mode_in;
   logic [tok_pkg::COUNT_BITS-1:0]   token_start_ff, token_start_in;
   logic [tok_pkg::COUNT_BITS-1:0]   token_length_ff, token_length_in;
   logic [tok_pkg::COUNT_BITS-1:0]   token_line_ff, token_line_in;
   logic [tok_pkg::COUNT_BITS-1:0]   byte_offset_ff, byte_offset_in;
   logic [tok_pkg::COUNT_BITS-1:0]   current_line_ff, current_line_in;
   logic [39:0]                      prefix_ff, prefix_in;
   logic [tok_pkg::TCOUNT_BITS-1:0]  count_ff, count_in, count_mid;
   logic                             dropped_ff, dropped_in, dropped_mid;
   logic [7:0]                       token_first_ff, token_first_in;

   logic                             take, do_idle, close_ok, alnum;
   logic                             cand0_v, cand1_v, keep0, keep1, drop0, drop1;
   tok_pkg::token_type               rec0, rec1;

   assign item_ready = space_ok;
   assign take       = item_valid && item_ready;

   always_comb begin
      mode_in         = mode_ff;
      token_start_in  = token_start_ff;
      token_length_in = token_length_ff;
      token_line_in   = token_line_ff;
      byte_offset_in  = byte_offset_ff;
      current_line_in = current_line_ff;
      prefix_in       = prefix_ff;
      token_first_in  = token_first_ff;
      do_idle         = 1'b0;
      cand0_v         = 1'b0;
      cand1_v         = 1'b0;
      alnum           = (item.cls == tok_pkg::CLS_DIGIT) || (item.cls == tok_pkg::CLS_ALPHA);

      // pending token as it would close now
      rec0.first    = token_first_ff;
      rec0.start    = tok_pkg::clamp_field(token_start_ff);
      rec0.line     = tok_pkg::clamp_field(token_line_ff);
      rec0.length   = tok_pkg::clamp_field(token_length_ff);
      rec0.overflow = 1'b0;
      rec0.last     = 1'b0;
      close_ok      = 1'b1;
      case (mode_ff)
         M_NUM:     rec0.kind = tok_pkg::KIND_NUM;
         M_IDENT:   rec0.kind = tok_pkg::keyword_kind(prefix_ff, token_length_ff);
         M_STRING:  rec0.kind = tok_pkg::KIND_STRING;
         M_COMMENT: rec0.kind = tok_pkg::KIND_COMMENT;
         M_EQ: begin
            rec0.kind   = tok_pkg::KIND_EQUALS;
            rec0.length = tok_pkg::FIELD_BITS'(1);
         end
         M_SLASH: begin
            rec0.kind   = tok_pkg::KIND_OPERATOR;
            rec0.length = tok_pkg::FIELD_BITS'(1);
         end
         default: begin
            rec0.kind = tok_pkg::KIND_UNKNOWN;
            close_ok  = 1'b0;
         end
      endcase

      // single-byte token that starts at this byte
      rec1.kind     = item.single_kind;
      rec1.first    = item.data;
      rec1.start    = tok_pkg::clamp_field(byte_offset_ff);
      rec1.line     = tok_pkg::clamp_field(current_line_ff);
      rec1.length   = tok_pkg::FIELD_BITS'(1);
      rec1.overflow = 1'b0;
      rec1.last     = 1'b0;

      if (take && mode_ff != M_DONE) begin
         if (item.cls == tok_pkg::CLS_END) begin
            cand0_v     = close_ok;
            cand1_v     = 1'b1;
            rec1.kind   = tok_pkg::KIND_END;
            rec1.first  = 8'h00;
            rec1.length = '0;
            rec1.last   = 1'b1;
            mode_in     = M_DONE;
         end else begin
            case (mode_ff)
               M_NUM: begin
                  if (item.cls == tok_pkg::CLS_DIGIT) begin
                     token_length_in = tok_pkg::sat_inc(token_length_ff);
                  end else begin
                     cand0_v = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               M_IDENT: begin
                  if (alnum) begin
                     if (token_length_ff < tok_pkg::COUNT_BITS'(5)) begin
                        prefix_in = {prefix_ff[31:0], item.data};
                     end
                     token_length_in = tok_pkg::sat_inc(token_length_ff);
                  end else begin
                     cand0_v = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               M_STRING: begin
                  if (item.cls == tok_pkg::CLS_QUOTE) begin
                     cand0_v = 1'b1;
                     mode_in = M_IDLE;
                  end else begin
                     token_length_in = tok_pkg::sat_inc(token_length_ff);
                  end
               end
               M_COMMENT: begin
                  if (item.cls == tok_pkg::CLS_NEWLINE) begin
                     cand0_v = 1'b1;
                     do_idle = 1'b1;
                  end else begin
                     token_length_in = tok_pkg::sat_inc(token_length_ff);
                  end
               end
               M_EQ: begin
                  cand0_v = 1'b1;
                  if (item.cls == tok_pkg::CLS_EQUALS) begin
                     rec0.kind   = tok_pkg::KIND_OPERATOR;
                     rec0.length = tok_pkg::FIELD_BITS'(2);
                     mode_in     = M_IDLE;
                  end else begin
                     do_idle = 1'b1;
                  end
               end
               M_SLASH: begin
                  if (item.cls == tok_pkg::CLS_SLASH) begin
                     mode_in         = M_COMMENT;
                     token_length_in = '0;
                  end else begin
                     cand0_v = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase
            byte_offset_in = tok_pkg::sat_inc(byte_offset_ff);
         end
      end

      if (do_idle) begin
         mode_in = M_IDLE;
         case (item.cls)
            tok_pkg::CLS_SPACE: ;
            tok_pkg::CLS_NEWLINE: current_line_in = tok_pkg::sat_inc(current_line_ff);
            default: begin
               token_start_in  = byte_offset_ff;
               token_line_in   = current_line_ff;
               token_first_in  = item.data;
               token_length_in = tok_pkg::COUNT_BITS'(1);
               case (item.cls)
                  tok_pkg::CLS_DIGIT: mode_in = M_NUM;
                  tok_pkg::CLS_ALPHA: begin
                     mode_in   = M_IDENT;
                     prefix_in = {32'h0, item.data};
                  end
                  tok_pkg::CLS_QUOTE: begin
                     mode_in         = M_STRING;
                     token_length_in = '0;
                  end
                  tok_pkg::CLS_EQUALS: mode_in = M_EQ;
                  tok_pkg::CLS_SLASH:  mode_in = M_SLASH;
                  default:             cand1_v = 1'b1;
               endcase
            end
         endcase
      end

      // token limit, applied in emission order
      keep0         = cand0_v && (count_ff < tok_pkg::TCOUNT_BITS'(tok_pkg::MAX_TOKENS));
      drop0         = cand0_v && !keep0;
      rec0.overflow = dropped_ff;
      count_mid     = count_ff + tok_pkg::TCOUNT_BITS'(keep0);
      dropped_mid   = dropped_ff || drop0;
      keep1         = cand1_v && (rec1.last ||
                      (count_mid < tok_pkg::TCOUNT_BITS'(tok_pkg::MAX_TOKENS)));
      drop1         = cand1_v && !keep1;
      rec1.overflow = dropped_mid;
      count_in      = count_mid + tok_pkg::TCOUNT_BITS'(keep1 && !rec1.last);
      dropped_in    = dropped_mid || drop1;

      push.wr0  = keep0 || keep1;
      push.wr1  = keep0 && keep1;
      push.tok0 = keep0 ? rec0 : rec1;
      push.tok1 = rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= M_IDLE;
         token_start_ff  <= '0;
         token_length_ff <= '0;
         token_line_ff   <= tok_pkg::COUNT_BITS'(1);
         byte_offset_ff  <= '0;
         current_line_ff <= tok_pkg::COUNT_BITS'(1);
         prefix_ff       <= '0;
         count_ff        <= '0;
         dropped_ff      <= 1'b0;
         token_first_ff  <= '0;
      end else begin
         mode_ff         <= mode_in;
         token_start_ff  <= token_start_in;
         token_length_ff <= token_length_in;
         token_line_ff   <= token_line_in;
         byte_offset_ff  <= byte_offset_in;
         current_line_ff <= current_line_in;
         prefix_ff       <= prefix_in;
         count_ff        <= count_in;
         dropped_ff      <= dropped_in;
         token_first_ff  <= token_first_in;
      end
   end

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tok_pkg::TCOUNT_BITS'(tok_pkg::MAX_TOKENS))
      else $error("token count beyond limit");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_DONE |=> mode_ff == M_DONE)
      else $error("scanner left done state");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_DONE |-> !push.wr0)
      else $error("token pushed after end of input");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.wr1 |-> push.wr0 && take)
      else $error("second token slot written alone");

endmodule

/* hdl/tok_queue.sv */
// ---------------------------------------------------------------------------
// tok_queue
// Token queue between scanner and result port; takes up to two tokens a
// cycle and hands out one.
// ---------------------------------------------------------------------------
module tok_queue (
   input  logic               clock,
   input  logic               reset,
   input  tok_pkg::push_type  push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tok_pkg::token_type head
);

   tok_pkg::token_type             q_ff [tok_pkg::OUT_DEPTH];
   tok_pkg::token_type             q_in [tok_pkg::OUT_DEPTH];
   logic [tok_pkg::OUT_PTR-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tok_pkg::OUT_PTR-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tok_pkg::OUT_PTR:0]      count_ff, count_in;
   logic                           pop;

   // room for the two tokens a single byte can produce
   assign space_ok  = (count_ff <= (tok_pkg::OUT_PTR + 1)'(tok_pkg::OUT_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign head      = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      q_in = q_ff;
      if (push.wr0) q_in[wr_ptr_ff] = push.tok0;
      if (push.wr1) q_in[wr_ptr_ff + tok_pkg::OUT_PTR'(1)] = push.tok1;
      wr_ptr_in = wr_ptr_ff + tok_pkg::OUT_PTR'(push.wr0) + tok_pkg::OUT_PTR'(push.wr1);
      rd_ptr_in = rd_ptr_ff + tok_pkg::OUT_PTR'(pop);
      count_in  = count_ff + (tok_pkg::OUT_PTR + 1)'(push.wr0)
                           + (tok_pkg::OUT_PTR + 1)'(push.wr1)
                           - (tok_pkg::OUT_PTR + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/source_byte_tokenizer_top.sv */
// ---------------------------------------------------------------------------
// source_byte_tokenizer_top
// Streaming tokenizer: bytes in, token records out.
// ---------------------------------------------------------------------------
// path: a byte passes the classified byte queue and the token queue registers
// throughput: one byte per cycle, set by the scanner step, while the token
//   queue has room; bytes that close two tokens drain one per rsp_ready cycle
// reset: synchronous, clears queues and scanner; line counts restart at 1
// after the end token every further byte is taken and yields nothing
module source_byte_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_marker,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [7:0]  rsp_first_byte,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_lexeme_length,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   logic               item_valid, item_ready, space_ok;
   tok_pkg::item_type  item;
   tok_pkg::push_type  push;
   tok_pkg::token_type head;

   tok_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_byte (req_source_byte),
      .req_end_marker  (req_end_marker),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   tok_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .space_ok   (space_ok),
      .push       (push)
   );

   tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_first_byte    = head.first;
   assign rsp_start_offset  = head.start;
   assign rsp_line_number   = head.line;
   assign rsp_lexeme_length = head.length;
   assign rsp_overflow      = head.overflow;
   assign rsp_last          = head.last;

endmodule
